[rtl/deq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Types, codes and sizes shared by the double-ended queue and its cells.
// ----------------------------------------------------------------------------
package deq_pkg;

  // storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int FUNC_W     = 3;

  // operation codes of an input word
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_HEAD = 3'd0,
    FN_PUSH_TAIL = 3'd1,
    FN_POP_HEAD  = 3'd2,
    FN_POP_TAIL  = 3'd3,
    FN_DUMP_FWD  = 3'd4,
    FN_DUMP_REV  = 3'd5
  } func_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // per-cycle move applied along the cell row
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_HEAD,
    OP_PUSH_TAIL,
    OP_POP_HEAD,
    OP_ROT_FWD,
    OP_ROT_REV
  } op_e;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  // input word
  typedef struct packed {
    logic [FUNC_W-1:0]            func;
    logic signed [DATA_WIDTH-1:0] value;
  } deq_in_t;

  // result word
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] word;
    logic [1:0]                   status;
    logic                         last;
  } deq_out_t;

  // command broadcast to every cell
  typedef struct packed {
    op_e              op;
    logic [CNT_W-1:0] cnt;
  } deq_cmd_t;

endpackage

[rtl/deq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_cell
// One storage slot of the queue row; takes its next word from itself, a
// neighbor, the wrap bus or the pushed value, as the broadcast command says.
// ----------------------------------------------------------------------------
module deq_cell (
  input  logic                                   clk_i,
  input  logic [deq_pkg::IDX_W-1:0]              idx_i,
  input  deq_pkg::deq_cmd_t                      cmd_i,
  input  logic signed [deq_pkg::DATA_WIDTH-1:0]  push_i,
  input  logic signed [deq_pkg::DATA_WIDTH-1:0]  low_i,
  input  logic signed [deq_pkg::DATA_WIDTH-1:0]  high_i,
  input  logic signed [deq_pkg::DATA_WIDTH-1:0]  wrap_i,
  output logic signed [deq_pkg::DATA_WIDTH-1:0]  word_o
);

  logic signed [deq_pkg::DATA_WIDTH-1:0] word_d, word_q;
  logic [deq_pkg::CNT_W-1:0]             pos;
  logic                                  is_head, is_fill, is_tail;

  // position flags relative to the occupied region
  assign pos     = deq_pkg::CNT_W'(idx_i);
  assign is_head = (idx_i == '0);
  assign is_fill = (pos == cmd_i.cnt);
  assign is_tail = ((pos + deq_pkg::CNT_W'(1)) == cmd_i.cnt);

  // next word select
  always_comb begin
    word_d = word_q;
    unique case (cmd_i.op)
      deq_pkg::OP_HOLD:      word_d = word_q;
      deq_pkg::OP_PUSH_HEAD: word_d = is_head ? push_i : low_i;
      deq_pkg::OP_PUSH_TAIL: word_d = is_fill ? push_i : word_q;
      deq_pkg::OP_POP_HEAD:  word_d = high_i;
      deq_pkg::OP_ROT_FWD:   word_d = is_tail ? wrap_i : high_i;
      deq_pkg::OP_ROT_REV:   word_d = is_head ? wrap_i : low_i;
      default:               word_d = word_q;
    endcase
  end

  // data register, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

[rtl/deq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Occupancy count, dump sequencer and result register of the queue.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  deq_pkg::deq_in_t                       in_i,
  input  logic signed [deq_pkg::DATA_WIDTH-1:0]  head_i,
  input  logic signed [deq_pkg::DATA_WIDTH-1:0]  tail_i,
  output deq_pkg::deq_cmd_t                      cmd_o,
  output logic                                   busy_o,
  output logic                                   strobe_o,
  output deq_pkg::deq_out_t                      result_o
);

  deq_pkg::state_e           state_d, state_q;
  logic [deq_pkg::CNT_W-1:0] count_d, count_q;
  logic [deq_pkg::CNT_W-1:0] remain_d, remain_q;
  logic                      rev_d, rev_q;
  logic                      strobe_d, strobe_q;
  deq_pkg::deq_out_t         res_d, res_q;
  deq_pkg::op_e              op;
  logic                      accept, empty, full, dump_req;

  assign accept   = start_i && (state_q == deq_pkg::S_IDLE);
  assign empty    = (count_q == '0);
  assign full     = (count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign dump_req = (in_i.func == deq_pkg::FN_DUMP_FWD) ||
                    (in_i.func == deq_pkg::FN_DUMP_REV);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      deq_pkg::S_IDLE: begin
        if (accept && dump_req && !empty) state_d = deq_pkg::S_DUMP;
      end
      deq_pkg::S_DUMP: begin
        if (remain_q == deq_pkg::CNT_W'(1)) state_d = deq_pkg::S_IDLE;
      end
      default: state_d = deq_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    op       = deq_pkg::OP_HOLD;
    count_d  = count_q;
    remain_d = remain_q;
    rev_d    = rev_q;
    strobe_d = 1'b0;
    res_d    = '0;
    unique case (state_q)
      deq_pkg::S_IDLE: begin
        if (accept) begin
          res_d.last = 1'b1;
          unique case (in_i.func)
            deq_pkg::FN_PUSH_HEAD, deq_pkg::FN_PUSH_TAIL: begin
              strobe_d = 1'b1;
              if (full) begin
                res_d.status = deq_pkg::ST_FULL;
              end else begin
                op      = (in_i.func == deq_pkg::FN_PUSH_HEAD) ?
                          deq_pkg::OP_PUSH_HEAD : deq_pkg::OP_PUSH_TAIL;
                count_d = count_q + deq_pkg::CNT_W'(1);
              end
            end
            deq_pkg::FN_POP_HEAD, deq_pkg::FN_POP_TAIL: begin
              strobe_d = 1'b1;
              if (empty) begin
                res_d.status = deq_pkg::ST_EMPTY;
              end else begin
                if (in_i.func == deq_pkg::FN_POP_HEAD) begin
                  op         = deq_pkg::OP_POP_HEAD;
                  res_d.word = head_i;
                end else begin
                  res_d.word = tail_i;
                end
                count_d = count_q - deq_pkg::CNT_W'(1);
              end
            end
            deq_pkg::FN_DUMP_FWD, deq_pkg::FN_DUMP_REV: begin
              if (empty) begin
                strobe_d     = 1'b1;
                res_d.status = deq_pkg::ST_EMPTY;
              end else begin
                remain_d = count_q;
                rev_d    = (in_i.func == deq_pkg::FN_DUMP_REV);
              end
            end
            default: res_d = '0;
          endcase
        end
      end
      deq_pkg::S_DUMP: begin
        // emit the end word and rotate the occupied region by one
        strobe_d   = 1'b1;
        res_d.word = rev_q ? tail_i : head_i;
        res_d.last = (remain_q == deq_pkg::CNT_W'(1));
        op         = rev_q ? deq_pkg::OP_ROT_REV : deq_pkg::OP_ROT_FWD;
        remain_d   = remain_q - deq_pkg::CNT_W'(1);
      end
      default: op = deq_pkg::OP_HOLD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= deq_pkg::S_IDLE;
      count_q  <= '0;
      remain_q <= '0;
      rev_q    <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      rev_q    <= rev_d;
      strobe_q <= strobe_d;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign cmd_o.op  = op;
  assign cmd_o.cnt = count_q;
  assign busy_o    = (state_q == deq_pkg::S_DUMP);
  assign strobe_o  = strobe_q;
  assign result_o  = res_q;

endmodule

[rtl/double_ended_queue.sv]
`timescale 1ns / 1ps
// push and pop: result in the cycle after the word is accepted, a new word every cycle
// dump of n stored words: each word is read in the dump state and then registered, one word a cycle;
//   busy while in the dump state, which rotates the cell row one step per emitted word
// empty dump, pop or full push: a single flagged result in the cycle after accept
// reset clears count and sequencer; cell contents stay undefined until pushed
// results are strobed for one cycle and cannot be stalled
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  deq_pkg::deq_in_t  in_i,
  output logic              strobe_o,
  output deq_pkg::deq_out_t result_o
);

  deq_pkg::deq_cmd_t                     cmd;
  logic signed [deq_pkg::DATA_WIDTH-1:0] words [deq_pkg::DEPTH];
  logic signed [deq_pkg::DATA_WIDTH-1:0] tail, wrap;
  logic [deq_pkg::IDX_W-1:0]             tail_idx;
  logic [deq_pkg::CNT_W-1:0]             tail_cnt;

  // sequencer and result register
  deq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .in_i     (in_i),
    .head_i   (words[0]),
    .tail_i   (tail),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

  // tail word select
  assign tail_cnt = cmd.cnt - deq_pkg::CNT_W'(1);
  assign tail_idx = tail_cnt[deq_pkg::IDX_W-1:0];
  assign tail     = words[tail_idx];
  assign wrap     = (cmd.op == deq_pkg::OP_ROT_REV) ? tail : words[0];

  // row of cells, head at index zero
  for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
    deq_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (deq_pkg::IDX_W'(i)),
      .cmd_i  (cmd),
      .push_i (in_i.value),
      .low_i  (words[(i == 0) ? 0 : i - 1]),
      .high_i (words[(i == deq_pkg::DEPTH - 1) ? i : i + 1]),
      .wrap_i (wrap),
      .word_o (words[i])
    );
  end

  // every dump cycle emits a word
  a_dump_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> strobe_o)
    else $error("dump cycle without result");

  // push and pop give exactly one final result next cycle
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (in_i.func == deq_pkg::FN_PUSH_HEAD ||
     in_i.func == deq_pkg::FN_PUSH_TAIL || in_i.func == deq_pkg::FN_POP_HEAD ||
     in_i.func == deq_pkg::FN_POP_TAIL)) |=> (strobe_o && result_o.last && !busy))
    else $error("push or pop result missing");

  // flagged results carry zero and end the item
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && result_o.status != deq_pkg::ST_OK) |->
      (result_o.word == '0 && result_o.last))
    else $error("flagged result not zero or not last");

  // the final dump word releases the input
  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy) && strobe_o && result_o.last) |-> !busy)
    else $error("busy after last dump word");

endmodule

[test/double_ended_queue_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Self-checking bench for the double-ended queue: a shadow deque predicts every
// result word, and a monitor compares each strobed result field by field.
// ----------------------------------------------------------------------------
module double_ended_queue_test;

  // function codes the block must ignore
  localparam logic [deq_pkg::FUNC_W-1:0] FN_UNUSED_LO = 3'd6;
  localparam logic [deq_pkg::FUNC_W-1:0] FN_UNUSED_HI = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  deq_pkg::deq_in_t  in_i;
  logic              strobe_o;
  deq_pkg::deq_out_t result_o;

  // shadow contents of the deque, front at index 0
  logic signed [deq_pkg::DATA_WIDTH-1:0] held_words[$];
  // results predicted but not yet seen
  deq_pkg::deq_out_t due_results[$];

  int errors;
  int words_sent;
  int results_checked;
  int full_hits;
  int empty_hits;
  int dump_words;
  int stall_cycles;

  double_ended_queue dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .in_i     (in_i),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string field,
                                 input logic [deq_pkg::DATA_WIDTH-1:0] got,
                                 input logic [deq_pkg::DATA_WIDTH-1:0] want);
    $display("mismatch on %s at result %0d: got %0h, want %0h",
             field, results_checked, got, want);
    errors++;
  endtask

  // apply one accepted word to the shadow deque and queue its results
  task automatic compute_deque_results(input deq_pkg::deq_in_t w);
    deq_pkg::deq_out_t r;
    int n;
    int back_idx;
    r = '0;
    r.status = deq_pkg::ST_OK;
    r.last = 1'b1;
    case (w.func)
      deq_pkg::FN_PUSH_HEAD, deq_pkg::FN_PUSH_TAIL: begin
        if (held_words.size() >= deq_pkg::DEPTH) begin
          r.status = deq_pkg::ST_FULL;
          full_hits++;
        end else if (w.func == deq_pkg::FN_PUSH_HEAD) begin
          held_words.insert(0, w.value);
        end else begin
          held_words.insert(held_words.size(), w.value);
        end
        due_results.insert(due_results.size(), r);
      end
      deq_pkg::FN_POP_HEAD, deq_pkg::FN_POP_TAIL: begin
        if (held_words.size() == 0) begin
          r.status = deq_pkg::ST_EMPTY;
          empty_hits++;
        end else if (w.func == deq_pkg::FN_POP_HEAD) begin
          r.word = held_words[0];
          held_words.delete(0);
        end else begin
          back_idx = held_words.size() - 1;
          r.word = held_words[back_idx];
          held_words.delete(back_idx);
        end
        due_results.insert(due_results.size(), r);
      end
      deq_pkg::FN_DUMP_FWD, deq_pkg::FN_DUMP_REV: begin
        n = held_words.size();
        if (n == 0) begin
          r.status = deq_pkg::ST_EMPTY;
          empty_hits++;
          due_results.insert(due_results.size(), r);
        end
        for (int i = 0; i < n; i++) begin
          r.word = held_words[(w.func == deq_pkg::FN_DUMP_FWD) ? i : n - 1 - i];
          r.last = (i == n - 1);
          due_results.insert(due_results.size(), r);
          dump_words++;
        end
      end
      default: ;
    endcase
  endtask

  // drive one word and hold it until the block takes it
  task automatic send_word(input logic [deq_pkg::FUNC_W-1:0] fn,
                           input logic signed [deq_pkg::DATA_WIDTH-1:0] val);
    deq_pkg::deq_in_t w;
    w.func = fn;
    w.value = val;
    start <= 1'b1;
    in_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    compute_deque_results(w);
    words_sent++;
  endtask

  // result monitor
  always @(posedge clk_i) begin
    deq_pkg::deq_out_t want;
    if (rst_ni && strobe_o) begin
      if (due_results.size() == 0) begin
        $display("unexpected result: word %0h status %0d last %0b",
                 result_o.word, result_o.status, result_o.last);
        errors++;
      end else begin
        want = due_results[0];
        due_results.delete(0);
        if (result_o.word !== want.word) report_mismatch("word", result_o.word, want.word);
        if (result_o.status !== want.status)
          report_mismatch("status", deq_pkg::DATA_WIDTH'(result_o.status),
                          deq_pkg::DATA_WIDTH'(want.status));
        if (result_o.last !== want.last)
          report_mismatch("last", deq_pkg::DATA_WIDTH'(result_o.last),
                          deq_pkg::DATA_WIDTH'(want.last));
        results_checked++;
      end
    end
  end

  // watchdog on cycles with no accepted word and no result
  always @(posedge clk_i) begin
    if ((rst_ni && start && !busy) || strobe_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // pops and dumps on an empty deque
  task automatic test_empty_deque();
    send_word(deq_pkg::FN_POP_HEAD, 32'sd0);
    send_word(deq_pkg::FN_POP_TAIL, 32'sd0);
    send_word(deq_pkg::FN_DUMP_FWD, 32'sd0);
    send_word(deq_pkg::FN_DUMP_REV, 32'sd0);
  endtask

  // codes outside the operation set give nothing
  task automatic test_unused_codes();
    send_word(FN_UNUSED_LO, 32'sh1234_5678);
    send_word(FN_UNUSED_HI, -32'sd1);
  endtask

  // extreme values at both ends
  task automatic test_extreme_values();
    send_word(deq_pkg::FN_PUSH_TAIL, 32'sh7fff_ffff);
    send_word(deq_pkg::FN_PUSH_HEAD, 32'sh8000_0000);
    send_word(deq_pkg::FN_PUSH_TAIL, -32'sd1);
    send_word(deq_pkg::FN_PUSH_HEAD, 32'sd0);
  endtask

  // fill up, push into a full deque at both ends, dump the full ring
  task automatic test_fill_to_full();
    while (held_words.size() < deq_pkg::DEPTH)
      send_word($urandom_range(0, 1) ? deq_pkg::FN_PUSH_HEAD : deq_pkg::FN_PUSH_TAIL,
                $urandom);
    send_word(deq_pkg::FN_PUSH_HEAD, $urandom);
    send_word(deq_pkg::FN_PUSH_TAIL, $urandom);
    send_word(deq_pkg::FN_DUMP_REV, 32'sd0);
  endtask

  // random traffic with push-heavy and pop-heavy stretches
  task automatic test_random_traffic(input int idle_pct, input int n_words);
    int sent;
    int pick;
    int push_pct;
    logic [deq_pkg::FUNC_W-1:0] fn;
    logic signed [deq_pkg::DATA_WIDTH-1:0] val;
    sent = 0;
    push_pct = 70;
    while (sent < n_words) begin
      if (sent % 20 == 0) push_pct = $urandom_range(0, 1) ? 70 : 25;
      // sender idles each cycle with the given chance
      while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        fn = $urandom_range(0, 1) ? FN_UNUSED_LO : FN_UNUSED_HI;
      end else if (pick < 3 + push_pct) begin
        fn = $urandom_range(0, 1) ? deq_pkg::FN_PUSH_HEAD : deq_pkg::FN_PUSH_TAIL;
      end else if (pick < 92) begin
        fn = $urandom_range(0, 1) ? deq_pkg::FN_POP_HEAD : deq_pkg::FN_POP_TAIL;
      end else begin
        fn = $urandom_range(0, 1) ? deq_pkg::FN_DUMP_FWD : deq_pkg::FN_DUMP_REV;
      end
      val = $urandom;
      case ($urandom_range(0, 19))
        0: val = 32'sh7fff_ffff;
        1: val = 32'sh8000_0000;
        2: val = 32'sd0;
        default: ;
      endcase
      send_word(fn, val);
      if (fn != FN_UNUSED_LO && fn != FN_UNUSED_HI) sent++;
    end
  endtask

  initial begin
    errors = 0;
    words_sent = 0;
    results_checked = 0;
    full_hits = 0;
    empty_hits = 0;
    dump_words = 0;
    rst_ni = 1'b0;
    start <= 1'b0;
    in_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_deque();
    test_unused_codes();
    test_extreme_values();
    test_fill_to_full();
    test_random_traffic(0, 44);
    test_random_traffic(58, 44);
    test_random_traffic(32, 44);

    // drain
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d words, checked %0d results (%0d dump words)",
             words_sent, results_checked, dump_words);
    $display("full-push drops %0d, empty pops/dumps %0d, mismatches %0d",
             full_hits, empty_hits, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[double_ended_queue.f]
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue.sv
test/double_ended_queue_test.sv
